// ===== rtl/core/grwh_pkg.sv =====
// Package for the grid ray wall height core: angle constants, status codes,
// divider widths and the quarter-wave sine table built at elaboration.
// No dependencies.
package grwh_pkg;

    localparam int unsigned QUARTER   = 1440;
    localparam int unsigned FULL_TURN = 5760;

    localparam int unsigned DIV_NW = 48;
    localparam int unsigned DIV_DW = 32;

    localparam logic [1:0] ST_WALL  = 2'd0;
    localparam logic [1:0] ST_LIMIT = 2'd1;
    localparam logic [1:0] ST_OUT   = 2'd2;

    typedef logic [15:0] t_sin_tab [0:QUARTER];

    function automatic t_sin_tab build_sin_tab();
        t_sin_tab tab;
        longint unsigned x;
        longint unsigned t;
        longint unsigned s;
        longint unsigned r;
        for (int k = 0; k <= QUARTER; k++) begin
            x = (64'(k) * 64'd3373259426) / 64'd2880;
            t = x;
            s = x;
            for (int n = 1; n <= 6; n++) begin
                t = (((t * x) >> 30) * x) >> 30;
                t = t / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    s = (s > t) ? s - t : 64'd0;
                end else begin
                    s = s + t;
                end
            end
            r = (s + 64'd16384) >> 15;
            if (r > 64'd32768) begin
                r = 64'd32768;
            end
            tab[k] = r[15:0];
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_TAB = build_sin_tab();

endpackage

// ===== rtl/core/grwh_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by all divisions of the core.
// Depends on grwh_pkg for the dividend and divisor widths.
module grwh_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [grwh_pkg::DIV_NW-1:0]   i_dividend,
    input  logic [grwh_pkg::DIV_DW-1:0]   i_divisor,
    output logic                          o_done,
    output logic [grwh_pkg::DIV_NW-1:0]   o_quot
);
    import grwh_pkg::*;

    localparam int CW = $clog2(DIV_NW);

    logic [DIV_DW-1:0] r_rem;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_dvs;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIV_DW:0]   shifted;
    logic [DIV_DW:0]   diff;
    logic              ge;

    assign shifted = {r_rem, r_quo[DIV_NW-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign ge      = shifted >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
                r_quo <= {r_quo[DIV_NW-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== rtl/core/grid_ray_wall_height_core.sv =====
// Grid ray caster: map store, cell walk sequencer and wall height output.
// Depends on grwh_pkg and grwh_div.
//
//  channel | valid       | ready       | word
//  in      | i_in_valid  | o_in_ready  | action, cell_index, cell_code, start, offset, angle
//  out     | o_out_valid | i_out_ready | wall_height, ray_distance, hit_status/col/row/side
//  cfg     | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
//
// A write word goes straight into the map while idle. A cast reads sine and cosine, checks
// the start cell, then per cell crossed runs up to three passes of the shared divider plus
// pick, move, map read and test. A wall hit at a nonzero distance adds a height pass.
// Up to MAX_STEPS crossings; the result then waits in S_FIN until the output register is free.
// Reset clears control state and sets map width and height to 32; the map is not cleared.
// The input is held off while a cast runs; a finished result waits in the output register.
module grid_ray_wall_height_core #(
    parameter int MAP_CELLS    = 4096,
    parameter int BLOCK_SIZE   = 64,
    parameter int MAX_STEPS    = 128,
    parameter int HEIGHT_SCALE = 277
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [11:0] i_cell_index,
    input  logic [3:0]  i_cell_code,
    input  logic [5:0]  i_start_col,
    input  logic [5:0]  i_start_row,
    input  logic [5:0]  i_offset_x,
    input  logic [5:0]  i_offset_y,
    input  logic [12:0] i_ray_angle,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_wall_height,
    output logic [23:0] o_ray_distance,
    output logic [1:0]  o_hit_status,
    output logic [5:0]  o_hit_col,
    output logic [5:0]  o_hit_row,
    output logic        o_hit_side,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data
);
    import grwh_pkg::*;

    localparam int AW = $clog2(MAP_CELLS);
    localparam logic [16:0] CELLS17 = 17'(MAP_CELLS);
    localparam logic [8:0]  BLK9 = 9'(BLOCK_SIZE);
    localparam logic [15:0] BLK_REM = (BLOCK_SIZE * 256 > 65535) ? 16'hFFFF
                                                                  : 16'(BLOCK_SIZE * 256);
    localparam logic [DIV_NW-1:0] HGT_NUM = DIV_NW'(HEIGHT_SCALE * BLOCK_SIZE * 256);
    localparam logic [7:0]  MAX_ST = 8'(MAX_STEPS);
    localparam logic [10:0] Q1 = 11'(QUARTER);

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_TS, S_TC, S_CHK, S_MAP, S_LOOK, S_DIV_GO, S_DIV_WT, S_PICK, S_MOVE, S_FIN
    } t_state;

    typedef enum logic [1:0] {OP_LX, OP_LY, OP_SHRINK, OP_HGT} t_op;

    typedef struct packed {
        logic        ok;
        logic [16:0] idx;
    } t_cell_chk;

    function automatic t_cell_chk cell_chk(input logic [6:0] col, input logic [6:0] row,
                                           input logic [6:0] w, input logic [6:0] h);
        t_cell_chk c;
        c.idx = 17'(row) * 17'(w) + 17'(col);
        c.ok  = (col < w) && (row < h) && (col <= 7'd63) && (row <= 7'd63)
                && (c.idx < CELLS17);
        return c;
    endfunction

    logic [3:0]  r_mem [0:MAP_CELLS-1];
    logic [3:0]  r_cell;
    logic [15:0] r_rom;

    t_state      r_state;
    t_op         r_op;
    logic [6:0]  r_map_w;
    logic [6:0]  r_map_h;
    logic [10:0] r_tsi;
    logic [10:0] r_tci;
    logic [15:0] r_ts;
    logic [15:0] r_tc;
    logic        r_xpos;
    logic        r_ypos;
    logic [5:0]  r_col;
    logic [5:0]  r_row;
    logic [16:0] r_idx;
    logic        r_ok;
    logic [15:0] r_rem_x;
    logic [15:0] r_rem_y;
    logic [23:0] r_dist;
    logic [7:0]  r_steps;
    logic        r_side;
    logic [31:0] r_lx;
    logic [31:0] r_ly;
    logic        r_selx;
    logic [5:0]  r_nc;
    logic [5:0]  r_nr;
    logic [16:0] r_nidx;
    logic        r_nok;
    logic [1:0]  r_status;
    logic [15:0] r_height;
    logic [DIV_NW-1:0] r_dvd;
    logic [DIV_DW-1:0] r_dvs;

    logic        r_out_valid;
    logic [15:0] r_o_height;
    logic [23:0] r_o_dist;
    logic [1:0]  r_o_status;
    logic [5:0]  r_o_col;
    logic [5:0]  r_o_row;
    logic        r_o_side;

    logic              div_done;
    logic [DIV_NW-1:0] div_quot;

    logic        in_take;
    logic [12:0] ang;
    logic [12:0] ang_r;
    logic        q_odd;
    logic        xpos_in;
    logic        ypos_in;
    logic [8:0]  oxc;
    logic [8:0]  oyc;
    logic [16:0] rx17;
    logic [16:0] ry17;
    t_cell_chk   start_chk;
    logic [16:0] wr_idx;
    logic [10:0] rom_addr;

    logic        selx;
    logic [31:0] len_short;
    logic [31:0] len_long;
    logic [15:0] rem_other;
    logic [32:0] dsum;
    logic [6:0]  nc7;
    logic [6:0]  nr7;
    logic        gone;
    t_cell_chk   next_chk;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_take     = i_in_valid && o_in_ready;

    assign ang = (i_ray_angle >= 13'(FULL_TURN)) ? i_ray_angle - 13'(FULL_TURN) : i_ray_angle;

    always_comb begin
        if (ang < 13'(QUARTER)) begin
            ang_r = ang;
            q_odd = 1'b0;
        end else if (ang < 13'(2 * QUARTER)) begin
            ang_r = ang - 13'(QUARTER);
            q_odd = 1'b1;
        end else if (ang < 13'(3 * QUARTER)) begin
            ang_r = ang - 13'(2 * QUARTER);
            q_odd = 1'b0;
        end else begin
            ang_r = ang - 13'(3 * QUARTER);
            q_odd = 1'b1;
        end
    end

    assign xpos_in = (ang < 13'(QUARTER)) || (ang > 13'(3 * QUARTER));
    assign ypos_in = (ang < 13'(2 * QUARTER));

    assign oxc  = (9'(i_offset_x) > BLK9) ? BLK9 : 9'(i_offset_x);
    assign oyc  = (9'(i_offset_y) > BLK9) ? BLK9 : 9'(i_offset_y);
    assign rx17 = {(xpos_in ? BLK9 - oxc : oxc), 8'd0};
    assign ry17 = {(ypos_in ? BLK9 - oyc : oyc), 8'd0};

    assign start_chk = cell_chk({1'b0, i_start_col}, {1'b0, i_start_row}, r_map_w, r_map_h);
    assign wr_idx    = 17'(i_cell_index);
    assign rom_addr  = (r_state == S_TS) ? r_tsi : r_tci;

    assign selx      = r_lx < r_ly;
    assign len_short = selx ? r_lx : r_ly;
    assign len_long  = selx ? r_ly : r_lx;
    assign rem_other = selx ? r_rem_y : r_rem_x;
    assign dsum      = 33'(len_short) + 33'(r_dist);

    always_comb begin
        nc7  = {1'b0, r_col};
        nr7  = {1'b0, r_row};
        gone = 1'b0;
        if (selx) begin
            if (r_xpos) begin
                nc7 = {1'b0, r_col} + 7'd1;
            end else if (r_col == 6'd0) begin
                gone = 1'b1;
            end else begin
                nc7 = {1'b0, r_col} - 7'd1;
            end
        end else begin
            if (r_ypos) begin
                nr7 = {1'b0, r_row} + 7'd1;
            end else if (r_row == 6'd0) begin
                gone = 1'b1;
            end else begin
                nr7 = {1'b0, r_row} - 7'd1;
            end
        end
    end

    assign next_chk = cell_chk(nc7, nr7, r_map_w, r_map_h);

    always_ff @(posedge i_clk) begin
        if (in_take && !i_action && (wr_idx < CELLS17)) begin
            r_mem[wr_idx[AW-1:0]] <= i_cell_code;
        end
        r_cell <= r_mem[r_idx[AW-1:0]];
        r_rom  <= SIN_TAB[rom_addr];
    end

    grwh_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DIV_GO),
        .i_dividend (r_dvd),
        .i_divisor  (r_dvs),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_LX;
            r_map_w     <= 7'd32;
            r_map_h     <= 7'd32;
            r_out_valid <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_rem_x     <= '0;
            r_rem_y     <= '0;
            r_dist      <= '0;
            r_steps     <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_WIDTH:  r_map_w <= i_cfg_data;
                    CFG_HEIGHT: r_map_h <= i_cfg_data;
                    default:    r_map_w <= r_map_w;
                endcase
            end
            if (r_out_valid && i_out_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_take && i_action) begin
                        r_tsi   <= q_odd ? Q1 - ang_r[10:0] : ang_r[10:0];
                        r_tci   <= q_odd ? ang_r[10:0] : Q1 - ang_r[10:0];
                        r_xpos  <= xpos_in;
                        r_ypos  <= ypos_in;
                        r_rem_x <= rx17[16] ? 16'hFFFF : rx17[15:0];
                        r_rem_y <= ry17[16] ? 16'hFFFF : ry17[15:0];
                        r_col   <= i_start_col;
                        r_row   <= i_start_row;
                        r_idx   <= start_chk.idx;
                        r_ok    <= start_chk.ok;
                        r_dist  <= '0;
                        r_steps <= '0;
                        r_side  <= 1'b0;
                        r_state <= S_TS;
                    end
                end
                S_TS: begin
                    r_state <= S_TC;
                end
                S_TC: begin
                    r_ts    <= r_rom;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_tc <= r_rom;
                    if (!r_ok) begin
                        r_status <= ST_OUT;
                        r_height <= '0;
                        r_state  <= S_FIN;
                    end else begin
                        r_state <= S_MAP;
                    end
                end
                S_MAP: begin
                    r_state <= S_LOOK;
                end
                S_LOOK: begin
                    if (r_cell != 4'd0) begin
                        r_status <= ST_WALL;
                        if (r_dist == 24'd0) begin
                            r_height <= 16'hFFFF;
                            r_state  <= S_FIN;
                        end else begin
                            r_dvd   <= HGT_NUM;
                            r_dvs   <= 32'(r_dist);
                            r_op    <= OP_HGT;
                            r_state <= S_DIV_GO;
                        end
                    end else if (r_steps >= MAX_ST) begin
                        r_status <= ST_LIMIT;
                        r_height <= '0;
                        r_state  <= S_FIN;
                    end else begin
                        r_dvd   <= {17'd0, r_rem_x, 15'd0};
                        r_dvs   <= 32'(r_tc);
                        r_op    <= OP_LX;
                        r_state <= S_DIV_GO;
                    end
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WT;
                end
                S_DIV_WT: begin
                    if (div_done) begin
                        unique case (r_op)
                            OP_LX: begin
                                r_lx    <= div_quot[31:0];
                                r_dvd   <= {17'd0, r_rem_y, 15'd0};
                                r_dvs   <= 32'(r_ts);
                                r_op    <= OP_LY;
                                r_state <= S_DIV_GO;
                            end
                            OP_LY: begin
                                r_ly    <= div_quot[31:0];
                                r_state <= S_PICK;
                            end
                            OP_SHRINK: begin
                                if (r_selx) begin
                                    r_rem_y <= div_quot[15:0];
                                end else begin
                                    r_rem_x <= div_quot[15:0];
                                end
                                r_state <= S_MOVE;
                            end
                            OP_HGT: begin
                                r_height <= (div_quot[DIV_NW-1:16] != '0) ? 16'hFFFF
                                                                         : div_quot[15:0];
                                r_state  <= S_FIN;
                            end
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                S_PICK: begin
                    r_selx  <= selx;
                    r_side  <= !selx;
                    r_dist  <= dsum[32:24] != '0 ? 24'hFFFFFF : dsum[23:0];
                    r_steps <= r_steps + 8'd1;
                    r_nc    <= nc7[5:0];
                    r_nr    <= nr7[5:0];
                    r_nidx  <= next_chk.idx;
                    r_nok   <= next_chk.ok && !gone;
                    r_dvd   <= DIV_NW'(rem_other * (len_long - len_short));
                    r_dvs   <= len_long;
                    if (selx) begin
                        r_rem_x <= BLK_REM;
                    end else begin
                        r_rem_y <= BLK_REM;
                    end
                    if (len_long == 32'd0) begin
                        if (selx) begin
                            r_rem_y <= '0;
                        end else begin
                            r_rem_x <= '0;
                        end
                        r_state <= S_MOVE;
                    end else begin
                        r_op    <= OP_SHRINK;
                        r_state <= S_DIV_GO;
                    end
                end
                S_MOVE: begin
                    if (!r_nok) begin
                        r_status <= ST_OUT;
                        r_height <= '0;
                        r_state  <= S_FIN;
                    end else begin
                        r_col   <= r_nc;
                        r_row   <= r_nr;
                        r_idx   <= r_nidx;
                        r_state <= S_MAP;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_o_height  <= r_height;
                        r_o_dist    <= r_dist;
                        r_o_status  <= r_status;
                        r_o_col     <= r_col;
                        r_o_row     <= r_row;
                        r_o_side    <= r_side;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_wall_height  = r_o_height;
    assign o_ray_distance = r_o_dist;
    assign o_hit_status   = r_o_status;
    assign o_hit_col      = r_o_col;
    assign o_hit_row      = r_o_row;
    assign o_hit_side     = r_o_side;

endmodule
